// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the trend alarm modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, ignored while reset is high
`define TCTA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset too
`define TCTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCTA_ASSERT(lbl, clk, rst, prop, msg)
`define TCTA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/tcta_pkg.sv =====
// ----------------------------------------------------------------------------
// tcta_pkg
// Types and constants of the temperature channel trend alarm.
// ----------------------------------------------------------------------------
package tcta_pkg;

  localparam int SAMPLE_W    = 15;
  localparam int READING_W   = 16;
  localparam int TREND_W     = 2;
  localparam int ALARM_W     = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 15;

  localparam int INACTIVE_CODE_DEF = 9990;

  typedef logic signed [SAMPLE_W-1:0]  temp_t;
  typedef logic signed [TREND_W-1:0]   trend_t;
  typedef logic signed [READING_W-1:0] reading_t;

  localparam temp_t LOW_LIMIT_RST  = 15'sd100;
  localparam temp_t HIGH_LIMIT_RST = 15'sd350;

  localparam trend_t TREND_FALL = -2'sd1;
  localparam trend_t TREND_FLAT = 2'sd0;
  localparam trend_t TREND_RISE = 2'sd1;

  typedef enum logic [ALARM_W-1:0] {
    ALARM_NONE = 2'd0,
    ALARM_LOW  = 2'd1,
    ALARM_HIGH = 2'd2
  } alarm_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_LIMIT  = 8'd0,
    REG_HIGH_LIMIT = 8'd1,
    REG_FAHRENHEIT = 8'd2,
    REG_SMOOTHING  = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    temp_t low_limit;
    temp_t high_limit;
    logic  fahrenheit_out;
    logic  thermocouple_smoothing;
  } cfg_t;

  // accepted value and trend sign of one beat, after the state update
  typedef struct packed {
    temp_t  held;
    trend_t trend;
  } step_res_t;

endpackage

// ===== sv/tcta_step.sv =====
// ----------------------------------------------------------------------------
// tcta_step
// Input register, held value / trend state update, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcta_step #(
  parameter int INACTIVE_CODE = tcta_pkg::INACTIVE_CODE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcta_pkg::temp_t     sample,
  input  logic                smoothing,
  output logic                res_valid,
  input  logic                res_ready,
  output tcta_pkg::step_res_t res
);
  import tcta_pkg::*;

  localparam temp_t INACTIVE = temp_t'(INACTIVE_CODE);

  // tenths to whole degrees, truncated toward zero; x*52429 >> 19 is exact below 2^18
  function automatic logic signed [11:0] whole_deg(input temp_t t);
    logic [14:0] mag;
    logic [31:0] prod;
    logic [11:0] q;
    mag  = t[14] ? 15'(-t) : 15'(t);
    prod = 32'(mag) * 32'd52429;
    q    = {1'b0, prod[29:19]};
    return t[14] ? $signed(12'd0 - q) : $signed(q);
  endfunction

  // signed divide by 3, truncated toward zero; x*43691 >> 17 is exact below 2^17
  function automatic temp_t div3(input logic signed [16:0] v);
    logic [15:0] mag;
    logic [32:0] prod;
    logic [14:0] q;
    mag  = v[16] ? 16'(-v) : 16'(v);
    prod = 33'(mag) * 33'd43691;
    q    = prod[31:17];
    return v[16] ? temp_t'(15'd0 - q) : temp_t'(q);
  endfunction

  logic                s0_valid;
  temp_t               s0_sample;
  temp_t               held;
  trend_t              last_trend;

  logic                adv0;
  logic                adv1;
  logic                load1;
  logic                prev_active;
  logic signed [11:0]  ws;
  logic signed [11:0]  wp;
  trend_t              sgn;
  logic signed [16:0]  avg_sum;
  temp_t               held_next;

  assign adv1     = !res_valid || res_ready;
  assign adv0     = !s0_valid || adv1;
  assign load1    = s0_valid && adv1;
  assign in_stall = !adv0;

  always_comb begin
    prev_active = (held != INACTIVE);
    ws          = whole_deg(s0_sample);
    wp          = whole_deg(held);
    avg_sum     = (17'(s0_sample) <<< 1) + 17'(held);

    if (!prev_active) begin
      sgn = TREND_FLAT;
    end else if (ws > wp) begin
      sgn = TREND_RISE;
    end else if (ws < wp) begin
      sgn = TREND_FALL;
    end else begin
      sgn = TREND_FLAT;
    end

    // a sample against the running trend is rejected, the old value stays
    priority if (s0_sample == INACTIVE) begin
      held_next = INACTIVE;
    end else if (last_trend == sgn) begin
      held_next = (smoothing && prev_active) ? div3(avg_sum) : s0_sample;
    end else begin
      held_next = held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      res_valid  <= 1'b0;
      held       <= INACTIVE;
      last_trend <= TREND_FLAT;
    end else begin
      if (adv0) begin
        s0_valid <= in_valid;
      end
      if (adv1) begin
        res_valid <= s0_valid;
      end
      if (load1) begin
        held       <= held_next;
        last_trend <= sgn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      s0_sample <= sample;
    end
    if (load1) begin
      res <= '{held: held_next, trend: sgn};
    end
  end

  `TCTA_ASSERT(a_inactive_clears_held, clk, rst, load1 && s0_sample == INACTIVE |=> held == INACTIVE, "inactive sample did not clear held value")
  `TCTA_ASSERT(a_flat_after_inactive, clk, rst, load1 && held == INACTIVE |=> res.trend == TREND_FLAT, "trend nonzero against inactive held value")
  `TCTA_ASSERT(a_res_matches_state, clk, rst, res_valid |-> (res.held == held && res.trend == last_trend), "result beat out of step with state")

endmodule

// ===== sv/tcta_report.sv =====
// ----------------------------------------------------------------------------
// tcta_report
// Alarm, change detection, unit conversion and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcta_report #(
  parameter int INACTIVE_CODE = tcta_pkg::INACTIVE_CODE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tcta_pkg::cfg_t      cfg,
  input  logic                res_valid,
  output logic                res_ready,
  input  tcta_pkg::step_res_t res,
  output logic                out_valid,
  input  logic                out_stall,
  output tcta_pkg::reading_t  reading,
  output tcta_pkg::trend_t    trend,
  output logic [1:0]          alarm,
  output logic                changed
);
  import tcta_pkg::*;

  localparam temp_t INACTIVE = temp_t'(INACTIVE_CODE);

  // signed divide by 5, truncated toward zero; x*52429 >> 18 is exact below 2^18
  function automatic reading_t div5(input logic signed [18:0] v);
    logic [17:0] mag;
    logic [35:0] prod;
    logic [15:0] q;
    mag  = v[18] ? 18'(-v) : 18'(v);
    prod = 36'(mag) * 36'd52429;
    q    = {1'b0, prod[32:18]};
    return v[18] ? $signed(16'd0 - q) : $signed(q);
  endfunction

  temp_t               reported_value;
  alarm_t              reported_alarm;

  logic                adv2;
  logic                load2;
  logic                held_active;
  alarm_t              alarm_next;
  logic                changed_next;
  logic signed [18:0]  f_sum;
  reading_t            reading_next;

  assign adv2      = !out_valid || !out_stall;
  assign load2     = res_valid && adv2;
  assign res_ready = adv2;

  always_comb begin
    held_active = (res.held != INACTIVE);

    priority if (!held_active) begin
      alarm_next = ALARM_NONE;
    end else if (res.held <= cfg.low_limit) begin
      alarm_next = ALARM_LOW;
    end else if (res.held >= cfg.high_limit) begin
      alarm_next = ALARM_HIGH;
    end else begin
      alarm_next = ALARM_NONE;
    end

    // change is judged on Celsius tenths, independent of the unit shown
    changed_next = (alarm_next != reported_alarm) || (res.held != reported_value);

    // F tenths = (9*C + 1600) / 5
    f_sum = (19'(res.held) <<< 3) + 19'(res.held) + 19'sd1600;
    if (!held_active || !cfg.fahrenheit_out) begin
      reading_next = 16'(res.held);
    end else begin
      reading_next = div5(f_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      reported_value <= INACTIVE;
      reported_alarm <= ALARM_NONE;
    end else begin
      if (adv2) begin
        out_valid <= res_valid;
      end
      if (load2) begin
        reported_value <= res.held;
        reported_alarm <= alarm_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      reading <= reading_next;
      trend   <= res.trend;
      alarm   <= alarm_next;
      changed <= changed_next;
    end
  end

  `TCTA_ASSERT(a_quiet_keeps_reported, clk, rst, load2 && !changed_next |=> ($stable(reported_value) && $stable(reported_alarm)), "reported state moved on an unchanged beat")
  `TCTA_ASSERT(a_alarm_needs_active, clk, rst, out_valid && alarm != ALARM_NONE |-> reported_value != INACTIVE, "alarm raised on inactive channel")
  `TCTA_ASSERT(a_alarm_is_reported, clk, rst, out_valid |-> alarm == reported_alarm, "output alarm differs from reported alarm")

endmodule

// ===== sv/temperature_channel_trend_alarm.sv =====
// A sample beat passes the input, step result and output registers in that order.
// Throughput: one beat per cycle unless stalled; the held value and trend registers
// close their update loop in the step stage; any unstalled cycle takes a new sample.
// Both sides stall through two registered stages and the output register.
// Reset (rst, synchronous, active high) empties the pipeline, sets the held and
// reported values to the inactive code, the trend flat, and the limits 10.0 / 35.0 C.
// ----------------------------------------------------------------------------
// temperature_channel_trend_alarm
// Temperature channel trend filter with min/max alarm and change flag.
// ----------------------------------------------------------------------------
module temperature_channel_trend_alarm #(
  parameter int INACTIVE_CODE = tcta_pkg::INACTIVE_CODE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tcta_pkg::temp_t                      sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tcta_pkg::reading_t                   reading,
  output tcta_pkg::trend_t                     trend,
  output logic [tcta_pkg::ALARM_W-1:0]         alarm,
  output logic                                 changed,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcta_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tcta_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tcta_pkg::*;

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  step_res_t res;

  assign cfg_ready = 1'b1;

  // unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{low_limit: LOW_LIMIT_RST, high_limit: HIGH_LIMIT_RST,
               fahrenheit_out: 1'b0, thermocouple_smoothing: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_LIMIT:  cfg.low_limit              <= $signed(cfg_data);
        REG_HIGH_LIMIT: cfg.high_limit             <= $signed(cfg_data);
        REG_FAHRENHEIT: cfg.fahrenheit_out         <= cfg_data[0];
        REG_SMOOTHING:  cfg.thermocouple_smoothing <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tcta_step #(
    .INACTIVE_CODE(INACTIVE_CODE)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .smoothing (cfg.thermocouple_smoothing),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tcta_report #(
    .INACTIVE_CODE(INACTIVE_CODE)
  ) u_report (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .reading   (reading),
    .trend     (trend),
    .alarm     (alarm),
    .changed   (changed)
  );

endmodule
